### rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// Default form: clk_i and rst_ni of the enclosing module.
`define ASSERT_CLK(lbl, prop) `ASSERT_IMPL(lbl, clk_i, rst_ni, prop)

`endif

### rtl/rgso_pkg.sv
package rgso_pkg;

  localparam int POS_W  = 48;         // position field width
  localparam int ROT_W  = 16;         // rotation entry width
  localparam int CFG_W  = 32;         // register width
  localparam int SUM_W  = POS_W + 1;  // position plus offset
  localparam int REM_W  = CFG_W + 1;  // signed remainder
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_GRID_X   = 3'd3,
    REG_GRID_Y   = 3'd4,
    REG_GRID_Z   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [POS_W-1:0] camera_x;
    logic signed [POS_W-1:0] camera_y;
    logic signed [POS_W-1:0] camera_z;
    logic signed [ROT_W-1:0] rot_00;
    logic signed [ROT_W-1:0] rot_01;
    logic signed [ROT_W-1:0] rot_02;
    logic signed [ROT_W-1:0] rot_10;
    logic signed [ROT_W-1:0] rot_11;
    logic signed [ROT_W-1:0] rot_12;
    logic signed [ROT_W-1:0] rot_20;
    logic signed [ROT_W-1:0] rot_21;
    logic signed [ROT_W-1:0] rot_22;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } out_t;

  typedef logic [2:0][SUM_W-1:0]            pos3_t;   // [axis]
  typedef logic [2:0][ROT_W-1:0]            rot3_t;   // [row]
  typedef logic [2:0][2:0][ROT_W-1:0]       rot_mat_t; // [row][col]
  typedef logic [2:0][REM_W-1:0]            rem3_t;   // [axis]
  typedef logic [2:0][CFG_W-1:0]            cfg3_t;

endpackage

### rtl/rgso_lane.sv
module rgso_lane #(
  parameter int ROT_FRAC_BITS = 14,
  parameter int DW            = 54
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  rgso_pkg::pos3_t                    p_i,
  input  rgso_pkg::rot3_t                    col_i,
  input  logic [rgso_pkg::CFG_W-1:0]         grid_i,
  output logic signed [rgso_pkg::REM_W-1:0]  r_o
);

  localparam int PHW = rgso_pkg::SUM_W - ROT_FRAC_BITS;
  localparam int PRH = PHW + rgso_pkg::ROT_W;
  localparam int PRL = ROT_FRAC_BITS + 1 + rgso_pkg::ROT_W;
  localparam int SLW = PRL + 2;
  localparam int GW  = rgso_pkg::CFG_W;
  localparam logic [SLW-1:0] HALF = SLW'(1) << (ROT_FRAC_BITS - 1);

  // Products of the split position with this column.
  logic signed [PRH-1:0] prod_h_q [3];
  logic signed [PRL-1:0] prod_l_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        prod_h_q[j] <= $signed(p_i[j][rgso_pkg::SUM_W-1:ROT_FRAC_BITS]) * $signed(col_i[j]);
        prod_l_q[j] <= $signed({1'b0, p_i[j][ROT_FRAC_BITS-1:0]}) * $signed(col_i[j]);
      end
    end
  end

  logic signed [DW-1:0]  sh, d;
  logic signed [SLW-1:0] sl, sl_r;
  logic [DW-1:0]         mag;

  always_comb begin
    sh   = DW'(prod_h_q[0]) + DW'(prod_h_q[1]) + DW'(prod_h_q[2]);
    sl   = SLW'(prod_l_q[0]) + SLW'(prod_l_q[1]) + SLW'(prod_l_q[2]) + $signed(HALF);
    sl_r = sl >>> ROT_FRAC_BITS;
    d    = sh + DW'(sl_r);
    mag  = d[DW-1] ? (~d + DW'(1)) : d;
  end

  // Restoring divider, one quotient bit per stage.
  logic [DW-1:0] num_q [DW+1];
  logic [GW-1:0] rem_q [DW+1];
  logic          neg_q [DW+1];
  logic          qb_q  [DW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= mag;
      rem_q[0] <= '0;
      neg_q[0] <= d[DW-1];
      qb_q[0]  <= 1'b0;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [GW:0] t;
    logic        ge;
    logic [GW:0] diff;
    always_comb begin
      t    = {rem_q[k], num_q[k][DW-1]};
      ge   = t >= {1'b0, grid_i};
      diff = t - {1'b0, grid_i};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= num_q[k] << 1;
        rem_q[k+1] <= ge ? diff[GW-1:0] : t[GW-1:0];
        neg_q[k+1] <= neg_q[k];
        qb_q[k+1]  <= ge;
      end
    end
  end

  // Round the quotient half to even, then restore the sign; a zero grid gives zero.
  logic [GW:0]                         m2, g2;
  logic                                up;
  logic signed [rgso_pkg::REM_W-1:0]   rr, r_d;

  always_comb begin
    m2  = {rem_q[DW], 1'b0};
    g2  = {1'b0, grid_i};
    up  = (m2 > g2) || ((m2 == g2) && qb_q[DW]);
    rr  = up ? ($signed({1'b0, rem_q[DW]}) - $signed(g2)) : $signed({1'b0, rem_q[DW]});
    r_d = neg_q[DW] ? -rr : rr;
    if (grid_i == '0) begin
      r_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_o <= r_d;
    end
  end

endmodule

### rtl/rgso_merge.sv
module rgso_merge #(
  parameter int ROT_FRAC_BITS = 14,
  parameter int DEPTH         = 57
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  rgso_pkg::pos3_t    p_i,
  input  rgso_pkg::rot_mat_t rot_i,
  input  rgso_pkg::rem3_t    r_i,
  output rgso_pkg::out_t     res_o
);

  localparam int PW = rgso_pkg::ROT_W + rgso_pkg::REM_W;
  localparam int SW = PW + 3;
  localparam int OW = rgso_pkg::POS_W;
  localparam logic [SW-1:0] HALF = SW'(1) << (ROT_FRAC_BITS - 1);

  // Hold position and rotation until the lanes deliver.
  rgso_pkg::pos3_t    p_dl_q   [DEPTH];
  rgso_pkg::rot_mat_t rot_dl_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_dl_q[0]   <= p_i;
      rot_dl_q[0] <= rot_i;
      for (int k = 1; k < DEPTH; k++) begin
        p_dl_q[k]   <= p_dl_q[k-1];
        rot_dl_q[k] <= rot_dl_q[k-1];
      end
    end
  end

  logic signed [PW-1:0] prod_q [3][3];
  rgso_pkg::pos3_t      p_pr_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_pr_q <= p_dl_q[DEPTH-1];
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[j][i] <= $signed(rot_dl_q[DEPTH-1][j][i]) * $signed(r_i[i]);
        end
      end
    end
  end

  logic signed [SW-1:0] s    [3];
  logic signed [SW-1:0] c    [3];
  logic signed [SW-1:0] diff [3];
  logic signed [OW-1:0] sat  [3];
  logic                 ovf  [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s[j]    = SW'(prod_q[j][0]) + SW'(prod_q[j][1]) + SW'(prod_q[j][2]) + $signed(HALF);
      c[j]    = s[j] >>> ROT_FRAC_BITS;
      diff[j] = SW'($signed(p_pr_q[j])) - c[j];
      ovf[j]  = (|diff[j][SW-1:OW-1]) && !(&diff[j][SW-1:OW-1]);
      if (ovf[j]) begin
        sat[j] = diff[j][SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end else begin
        sat[j] = diff[j][OW-1:0];
      end
    end
    res_o.pos_x = sat[0];
    res_o.pos_y = sat[1];
    res_o.pos_z = sat[2];
  end

endmodule

### rtl/rotated_grid_snap_offset.sv
// Rotated grid snap with offset.
// Input channel (in_valid_i/in_ready_o/in_i): one item carries a camera
// position (Q31.16) and a 3x3 rotation (Q1.14). Output channel
// (out_valid_o/out_ready_i/out_o): one snapped position per item, in order.
// APB port: offsets at byte 0/4/8, grid steps at 12/16/20; write only idle.
// Throughput: one item per cycle while in_ready_o is high. Three lanes, one
// per rotated axis, each run a restoring divider that retires one quotient
// bit per stage. From accept to out_valid_o: input register, projection
// products, magnitude, 68 - ROT_FRAC_BITS divider stages, remainder fixup,
// correction product, output register.
// Stall: an output register plus one skid entry sit behind the pipeline; the
// pipeline only halts (in_ready_o low) once the skid entry is full.
// Reset: registers clear to zero, pipeline and output empty.
module rotated_grid_snap_offset #(
  parameter int ROT_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rgso_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rgso_pkg::out_t                out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgso_pkg::ADDR_W-1:0]   paddr,
  input  logic [rgso_pkg::CFG_W-1:0]    pwdata,
  output logic [rgso_pkg::CFG_W-1:0]    prdata,
  output logic                          pready
);

`include "assert_macros.svh"

  localparam int DW = 68 - ROT_FRAC_BITS;  // projection width
  localparam int LL = DW + 3;              // lane latency
  localparam int NP = LL + 2;              // pipeline stages ahead of output

  // ---------------------------------------------------------------- config
  rgso_pkg::cfg3_t    offset_q, grid_q;
  rgso_pkg::reg_idx_e idx;

  assign idx    = rgso_pkg::reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      grid_q   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        rgso_pkg::REG_OFFSET_X: offset_q[0] <= pwdata;
        rgso_pkg::REG_OFFSET_Y: offset_q[1] <= pwdata;
        rgso_pkg::REG_OFFSET_Z: offset_q[2] <= pwdata;
        rgso_pkg::REG_GRID_X:   grid_q[0]   <= pwdata;
        rgso_pkg::REG_GRID_Y:   grid_q[1]   <= pwdata;
        rgso_pkg::REG_GRID_Z:   grid_q[2]   <= pwdata;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rgso_pkg::REG_OFFSET_X: prdata = offset_q[0];
      rgso_pkg::REG_OFFSET_Y: prdata = offset_q[1];
      rgso_pkg::REG_OFFSET_Z: prdata = offset_q[2];
      rgso_pkg::REG_GRID_X:   prdata = grid_q[0];
      rgso_pkg::REG_GRID_Y:   prdata = grid_q[1];
      rgso_pkg::REG_GRID_Z:   prdata = grid_q[2];
      default:                prdata = '0;
    endcase
  end

  // -------------------------------------------------------- pipeline control
  // The whole pipeline moves as one while the skid entry is empty.
  logic          en;
  logic          in_acc;
  logic [NP-1:0] v_q;
  logic          skid_v_q, out_v_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NP-2:0], in_valid_i};
    end
  end

  // ----------------------------------------------------------- input stage
  // Add the offset at full width; saturate only at the end.
  rgso_pkg::pos3_t    p_d, p_q;
  rgso_pkg::rot_mat_t rot_d, rot_q;

  always_comb begin
    p_d[0] = rgso_pkg::SUM_W'(in_i.camera_x) + rgso_pkg::SUM_W'($signed(offset_q[0]));
    p_d[1] = rgso_pkg::SUM_W'(in_i.camera_y) + rgso_pkg::SUM_W'($signed(offset_q[1]));
    p_d[2] = rgso_pkg::SUM_W'(in_i.camera_z) + rgso_pkg::SUM_W'($signed(offset_q[2]));
    rot_d[0][0] = in_i.rot_00;
    rot_d[0][1] = in_i.rot_01;
    rot_d[0][2] = in_i.rot_02;
    rot_d[1][0] = in_i.rot_10;
    rot_d[1][1] = in_i.rot_11;
    rot_d[1][2] = in_i.rot_12;
    rot_d[2][0] = in_i.rot_20;
    rot_d[2][1] = in_i.rot_21;
    rot_d[2][2] = in_i.rot_22;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q   <= p_d;
      rot_q <= rot_d;
    end
  end

  // ----------------------------------------------------------------- lanes
  // Lane i projects onto column i of R and takes the remainder by grid i.
  rgso_pkg::rem3_t r_w;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rgso_pkg::rot3_t col;
    logic signed [rgso_pkg::REM_W-1:0] r;
    for (genvar j = 0; j < 3; j++) begin : g_col
      assign col[j] = rot_q[j][i];
    end
    rgso_lane #(
      .ROT_FRAC_BITS (ROT_FRAC_BITS),
      .DW            (DW)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .p_i    (p_q),
      .col_i  (col),
      .grid_i (grid_q[i]),
      .r_o    (r)
    );
    assign r_w[i] = r;
  end

  // ----------------------------------------------------------------- merge
  rgso_pkg::out_t res;

  rgso_merge #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS),
    .DEPTH         (LL)
  ) u_merge (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (p_q),
    .rot_i (rot_q),
    .r_i   (r_w),
    .res_o (res)
  );

  // ------------------------------------------------------ output and skid
  rgso_pkg::out_t out_q, skid_q;
  logic           take;

  assign take = en && v_q[NP-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      // Output slot frees: refill from skid first, else from the pipeline.
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= take;
      end
    end else if (take) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (take) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // ------------------------------------------------------------ assertions
  `ASSERT_CLK(a_skid_needs_out, skid_v_q |-> out_v_q)
  `ASSERT_CLK(a_accept_enters, in_acc |=> v_q[0])
  `ASSERT_CLK(a_skid_on_stall, $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))

endmodule
